// File: hdl/lva_pkg.sv
// Shared types and codes for the LRU voice allocator.
`timescale 1ns / 1ps
package lva_pkg;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_SILENCE  = 2'd2,
    OP_ACK      = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [3:0] channel;
    logic [6:0] note_number;
    logic [6:0] note_velocity;
    logic [3:0] ack_voice;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  voice_chosen;
    logic        stolen;
    logic [15:0] released_mask;
  } out_t;

  // one voice record as kept in the voice RAM
  typedef struct packed {
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [31:0] age_stamp;
  } voice_rec_t;

endpackage

// File: hdl/lva_voice_ram.sv
// Voice record RAM: one write port, one registered read port.
`timescale 1ns / 1ps
module lva_voice_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  lva_pkg::voice_rec_t wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output lva_pkg::voice_rec_t rdata
);
  import lva_pkg::*;

  voice_rec_t mem [DEPTH];
  voice_rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/lru_voice_allocator.sv
// Top level of the LRU voice allocator: sequencer, voice flags and age compare.
`timescale 1ns / 1ps
// Voice allocator for VOICES synth voices.
// Input: a command is transferred on a rising edge with start high and busy low;
// busy stays high until the command is done. Result: out_valid is high for one
// cycle with out_data; the receiver cannot stall, so it must take it then.
// Config: cfg_we writes cfg_wdata into the channel active mask; write it
// only while busy is low and no result is pending.
// Timing: note on and note off on an active channel walk the voice RAM one
// voice per cycle through a single signed age comparator and match compare,
// and the result strobe comes in the same cycle as busy falls. Silence all,
// acknowledge and events on an inactive channel skip the walk and go
// straight to the apply state. A new command may be started in the cycle of
// the result strobe.
// Reset: all voice flags clear, every voice reads as never used, the use
// counter and the channel mask are zero; the RAM needs no clearing since an
// unassigned voice never uses its RAM record.
module lru_voice_allocator #(
  parameter int VOICES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  lva_pkg::in_t  in_data,
  output logic          out_valid,
  output lva_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata
);
  import lva_pkg::*;

  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  state_t            state_r, state_nxt;
  in_t               in_r, in_nxt;
  logic [15:0]       cfg_mask_r, cfg_mask_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              any_free_r, any_free_nxt;
  logic              best_vld_r, best_vld_nxt;
  logic [IW-1:0]     best_idx_r, best_idx_nxt;
  logic [31:0]       best_age_r, best_age_nxt;
  logic [VOICES-1:0] rel_v_r, rel_v_nxt;
  logic [VOICES-1:0] on_r, on_nxt;
  logic [VOICES-1:0] changed_r, changed_nxt;
  logic [VOICES-1:0] needs_clear_r, needs_clear_nxt;
  logic [VOICES-1:0] assigned_r, assigned_nxt;
  logic [31:0]       use_cnt_r, use_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_raddr;
  voice_rec_t        ram_wdata, ram_rdata;

  lva_voice_ram #(
    .DEPTH(VOICES),
    .AW   (IW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(best_idx_r),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ram_raddr = cnt_r[IW-1:0];

  always_comb begin
    logic          active;
    logic [IW-1:0] pidx;
    logic          cand;
    logic [31:0]   age;
    logic [63:0]   rel_wide;
    logic [31:0]   chosen_wide;
    logic [CW-1:0] pidx_c;

    state_nxt       = state_r;
    in_nxt          = in_r;
    cfg_mask_nxt    = cfg_mask_r;
    cnt_nxt         = cnt_r;
    any_free_nxt    = any_free_r;
    best_vld_nxt    = best_vld_r;
    best_idx_nxt    = best_idx_r;
    best_age_nxt    = best_age_r;
    rel_v_nxt       = rel_v_r;
    on_nxt          = on_r;
    changed_nxt     = changed_r;
    needs_clear_nxt = needs_clear_r;
    assigned_nxt    = assigned_r;
    use_cnt_nxt     = use_cnt_r;
    out_valid_nxt   = 1'b0;
    out_data_nxt    = out_data_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_wdata       = '{channel: in_r.channel, note: in_r.note_number, age_stamp: use_cnt_r};
    active          = cfg_mask_r[in_r.channel];
    pidx_c          = cnt_r - CW'(1);
    pidx            = pidx_c[IW-1:0];
    cand            = 1'b0;
    age             = '1;
    rel_wide        = '0;
    chosen_wide     = 32'(best_idx_r);

    if (cfg_we) begin
      cfg_mask_nxt = cfg_wdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          in_nxt       = in_data;
          cnt_nxt      = '0;
          best_vld_nxt = 1'b0;
          rel_v_nxt    = '0;
          any_free_nxt = |(~on_r & ~changed_r);
          if (((in_data.opcode == OP_NOTE_ON) || (in_data.opcode == OP_NOTE_OFF)) &&
              cfg_mask_r[in_data.channel]) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_APPLY;
          end
        end
      end

      ST_SCAN: begin
        ram_re = (32'(cnt_r) < VOICES);
        // RAM data arrives in the cycle after its address: handle the previous voice
        if (cnt_r != '0) begin
          if (in_r.opcode == OP_NOTE_ON) begin
            cand = !any_free_r || (!on_r[pidx] && !changed_r[pidx]);
            age  = assigned_r[pidx] ? ram_rdata.age_stamp : '1;
            if (cand && (!best_vld_r || ($signed(age) < $signed(best_age_r)))) begin
              best_vld_nxt = 1'b1;
              best_idx_nxt = pidx;
              best_age_nxt = age;
            end
          end else if (assigned_r[pidx] && (ram_rdata.channel == in_r.channel) &&
                       (ram_rdata.note == in_r.note_number)) begin
            rel_v_nxt[pidx]   = on_r[pidx];
            changed_nxt[pidx] = 1'b1;
            on_nxt[pidx]      = 1'b0;
          end
        end
        if (32'(cnt_r) == VOICES) begin
          state_nxt = ST_APPLY;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      ST_APPLY: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        state_nxt     = ST_IDLE;
        case (in_r.opcode)
          OP_NOTE_ON: begin
            if (active) begin
              ram_we                      = 1'b1;
              use_cnt_nxt                 = use_cnt_r + 32'd1;
              needs_clear_nxt[best_idx_r] = !any_free_r;
              changed_nxt[best_idx_r]     = 1'b1;
              on_nxt[best_idx_r]          = 1'b1;
              assigned_nxt[best_idx_r]    = 1'b1;
              out_data_nxt.accepted       = 1'b1;
              out_data_nxt.voice_chosen   = chosen_wide[3:0];
              out_data_nxt.stolen         = !any_free_r;
            end
          end
          OP_NOTE_OFF: begin
            if (active) begin
              rel_wide                   = 64'(rel_v_r);
              out_data_nxt.accepted      = 1'b1;
              out_data_nxt.released_mask = rel_wide[15:0];
            end
          end
          OP_SILENCE: begin
            rel_wide                   = 64'(on_r);
            out_data_nxt.accepted      = 1'b1;
            out_data_nxt.released_mask = rel_wide[15:0];
            on_nxt                     = '0;
            needs_clear_nxt            = '1;
            changed_nxt                = '1;
          end
          default: begin
            if (32'(in_r.ack_voice) < VOICES) begin
              out_data_nxt.accepted = 1'b1;
              for (int i = 0; i < VOICES; i++) begin
                if (32'(in_r.ack_voice) == i) begin
                  changed_nxt[i] = 1'b0;
                end
              end
            end
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cfg_mask_r    <= '0;
      on_r          <= '0;
      changed_r     <= '0;
      needs_clear_r <= '0;
      assigned_r    <= '0;
      use_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cfg_mask_r    <= cfg_mask_nxt;
      on_r          <= on_nxt;
      changed_r     <= changed_nxt;
      needs_clear_r <= needs_clear_nxt;
      assigned_r    <= assigned_nxt;
      use_cnt_r     <= use_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    in_r       <= in_nxt;
    cnt_r      <= cnt_nxt;
    any_free_r <= any_free_nxt;
    best_vld_r <= best_vld_nxt;
    best_idx_r <= best_idx_nxt;
    best_age_r <= best_age_nxt;
    rel_v_r    <= rel_v_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/lva_checker.sv
// Port-level checks for the LRU voice allocator, bound to the top level.
`timescale 1ns / 1ps
module lva_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input lva_pkg::out_t out_data,
  input logic          out_valid
);
  import lva_pkg::*;

  // every transfer in starts a busy period
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after a transfer in");

  // the result strobe comes in the cycle in which each busy period ends
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid)
    else $error("no result after busy fell");

  // strobe lasts a single cycle
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held more than one cycle");

  // a rejected event carries no voice information
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |->
      (out_data.voice_chosen == 4'd0) && !out_data.stolen &&
      (out_data.released_mask == 16'd0))
    else $error("rejected event reports voice data");

endmodule

bind lru_voice_allocator lva_checker u_lva_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_data (out_data),
  .out_valid(out_valid)
);

// File: verif/tb.sv
// Self-checking testbench for the LRU voice allocator: directed and random events.
`timescale 1ns / 1ps
module tb;
  import lva_pkg::*;

  localparam int NUM_VOICES     = 16;
  localparam int SETTLE_CYCLES  = NUM_VOICES + 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [3:0] ch;
    logic [6:0] note;
  } held_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_data = '0;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // predictor state
  logic [15:0] chan_mask;
  bit          v_on[NUM_VOICES];
  bit          v_changed[NUM_VOICES];
  bit          v_needs_clear[NUM_VOICES];
  bit          v_assigned[NUM_VOICES];
  logic [3:0]  v_chan[NUM_VOICES];
  logic [6:0]  v_note[NUM_VOICES];
  logic [6:0]  v_vel[NUM_VOICES];
  int          v_age_stamp[NUM_VOICES];
  int unsigned use_count;

  in_t   pending_events[$];
  out_t  expected_results[$];
  held_t held_notes[$];
  int    mismatches = 0;
  int    gap_left = 0;
  int    idle_cycles = 0;
  bit    burst_phase = 1'b0;

  lru_voice_allocator #(.VOICES(NUM_VOICES)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one event to the voice state and return the allocator's answer.
  function automatic out_t voice_alloc_step(in_t ev);
    out_t r;
    bit   active;
    bit   any_free;
    int   best;
    r = '0;
    active = chan_mask[ev.channel];
    case (ev.opcode)
      OP_NOTE_ON: if (active) begin
        any_free = 1'b0;
        for (int i = 0; i < NUM_VOICES; i++)
          if (!v_on[i] && !v_changed[i]) any_free = 1'b1;
        best = -1;
        for (int i = 0; i < NUM_VOICES; i++) begin
          if (!any_free || (!v_on[i] && !v_changed[i])) begin
            // signed age: a never-used voice (-1) is the oldest
            if (best < 0 || v_age_stamp[i] < v_age_stamp[best]) best = i;
          end
        end
        v_age_stamp[best] = int'(use_count);
        use_count++;
        v_needs_clear[best] = !any_free;
        v_changed[best] = 1'b1;
        v_on[best] = 1'b1;
        v_assigned[best] = 1'b1;
        v_chan[best] = ev.channel;
        v_note[best] = ev.note_number;
        v_vel[best] = ev.note_velocity;
        r.accepted = 1'b1;
        r.voice_chosen = 4'(best);
        r.stolen = !any_free;
      end
      OP_NOTE_OFF: if (active) begin
        for (int i = 0; i < NUM_VOICES; i++) begin
          if (v_assigned[i] && v_chan[i] == ev.channel && v_note[i] == ev.note_number) begin
            if (v_on[i]) r.released_mask[i] = 1'b1;
            v_changed[i] = 1'b1;
            v_on[i] = 1'b0;
          end
        end
        r.accepted = 1'b1;
      end
      OP_SILENCE: begin
        for (int i = 0; i < NUM_VOICES; i++) begin
          if (v_on[i]) r.released_mask[i] = 1'b1;
          v_on[i] = 1'b0;
          v_needs_clear[i] = 1'b1;
          v_changed[i] = 1'b1;
        end
        r.accepted = 1'b1;
      end
      default: begin
        if (int'(ev.ack_voice) < NUM_VOICES) begin
          v_changed[ev.ack_voice] = 1'b0;
          r.accepted = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [3:0] pick_channel();
    logic [3:0] c;
    c = 4'($urandom_range(0, 15));
    if (chan_mask != '0 && $urandom_range(0, 9) < 8) begin
      while (!chan_mask[c]) c = 4'($urandom_range(0, 15));
    end
    return c;
  endfunction

  task automatic add_event(input opcode_t op, input logic [3:0] ch, input logic [6:0] note,
                           input logic [6:0] vel, input logic [3:0] ackv);
    in_t ev;
    ev.opcode = op;
    ev.channel = ch;
    ev.note_number = note;
    ev.note_velocity = vel;
    ev.ack_voice = ackv;
    pending_events.push_back(ev);
  endtask

  task automatic queue_random_events(input int count);
    in_t ev;
    int  r;
    int  k;
    repeat (count) begin
      ev.opcode = opcode_t'($urandom_range(0, 3));
      ev.channel = 4'($urandom_range(0, 15));
      ev.note_number = 7'($urandom_range(0, 127));
      ev.note_velocity = 7'($urandom_range(0, 127));
      ev.ack_voice = 4'($urandom_range(0, 15));
      r = $urandom_range(0, 99);
      if (r < 15) begin
        // leave as noise
      end else if (r < 50) begin
        ev.opcode = OP_NOTE_ON;
        ev.channel = pick_channel();
        // narrow note pool so several voices share a note
        if ($urandom_range(0, 1) == 1) ev.note_number = 7'(60 + $urandom_range(0, 7));
        held_notes.push_back('{ch: ev.channel, note: ev.note_number});
        if (held_notes.size() > 32) held_notes.delete(0);
      end else if (r < 70) begin
        ev.opcode = OP_NOTE_OFF;
        if (held_notes.size() > 0) begin
          k = $urandom_range(0, held_notes.size() - 1);
          ev.channel = held_notes[k].ch;
          ev.note_number = held_notes[k].note;
          if ($urandom_range(0, 3) != 0) held_notes.delete(k);
        end else begin
          ev.channel = pick_channel();
        end
      end else if (r < 96) begin
        ev.opcode = OP_ACK;
      end else begin
        ev.opcode = OP_SILENCE;
        held_notes.delete();
      end
      pending_events.push_back(ev);
    end
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_channel_mask(input logic [15:0] m);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    chan_mask = m;
    cfg_we <= 1'b0;
    cfg_wdata <= 16'($urandom_range(0, 65535));
  endtask

  // Driver: present queued events, hold each until the transfer.
  always @(posedge clk) begin : driver
    int g;
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.push_back(voice_alloc_step(in_data));
        pending_events.delete(0);
        g = $urandom_range(0, 99);
        if (burst_phase || g < 55) g = 0;
        else if (g < 85) g = $urandom_range(1, 3);
        else if (g < 97) g = $urandom_range(4, 12);
        else g = $urandom_range(20, 60);
        gap_left = g;
        if (g == 0 && pending_events.size() > 0) in_data <= pending_events[0];
        else start <= 1'b0;
      end else if (!start) begin
        if (gap_left > 0) gap_left--;
        else if (pending_events.size() > 0) begin
          start <= 1'b1;
          in_data <= pending_events[0];
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest expectation.
  always @(posedge clk) begin : monitor
    out_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] unexpected result: %p", $realtime, out_data);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_data !== want) begin
          if (mismatches < 10)
            $display("[%0t] mismatch: acc %0d/%0d voice %0d/%0d stolen %0d/%0d rel %h/%h",
                     $realtime, want.accepted, out_data.accepted,
                     want.voice_chosen, out_data.voice_chosen,
                     want.stolen, out_data.stolen,
                     want.released_mask, out_data.released_mask);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] phase_mask[7];
    int          phase_len[7];
    chan_mask = '0;
    use_count = 0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      v_on[i] = 1'b0;
      v_changed[i] = 1'b0;
      v_needs_clear[i] = 1'b0;
      v_assigned[i] = 1'b0;
      v_chan[i] = '0;
      v_note[i] = '0;
      v_vel[i] = '0;
      v_age_stamp[i] = -1;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // mask still at reset: note events are refused, silence and ack go through
    add_event(OP_NOTE_ON, 4'd0, 7'd0, 7'd0, 4'd0);
    add_event(OP_NOTE_OFF, 4'd15, 7'd127, 7'd127, 4'd15);
    add_event(OP_SILENCE, 4'd7, 7'd64, 7'd1, 4'd3);
    add_event(OP_ACK, 4'd2, 7'd10, 7'd20, 4'd0);
    add_event(OP_ACK, 4'd9, 7'd90, 7'd30, 4'd15);

    write_channel_mask(16'hFFFF);
    // all voices changed after silence: first note on steals
    add_event(OP_NOTE_ON, 4'd0, 7'd0, 7'd0, 4'd0);
    for (int i = 0; i < NUM_VOICES; i++) add_event(OP_ACK, 4'd0, 7'd0, 7'd0, 4'(i));
    // mixed: free voice pick, duplicate notes released together, no-match off
    add_event(OP_NOTE_ON, 4'd15, 7'd127, 7'd127, 4'd15);
    add_event(OP_NOTE_ON, 4'd15, 7'd127, 7'd64, 4'd0);
    add_event(OP_NOTE_OFF, 4'd15, 7'd127, 7'd0, 4'd0);
    add_event(OP_NOTE_OFF, 4'd3, 7'd5, 7'd0, 4'd0);
    add_event(OP_ACK, 4'd0, 7'd0, 7'd0, 4'd1);
    add_event(OP_NOTE_ON, 4'd7, 7'd60, 7'd100, 4'd0);
    add_event(OP_SILENCE, 4'd0, 7'd0, 7'd0, 4'd0);
    add_event(OP_NOTE_ON, 4'd9, 7'd1, 7'd127, 4'd0);

    phase_mask[0] = 16'hFFFF;                  phase_len[0] = 70;
    phase_mask[1] = 16'($urandom_range(0, 65535)); phase_len[1] = 70;
    phase_mask[2] = 16'h0001;                  phase_len[2] = 50;
    phase_mask[3] = 16'h8000;                  phase_len[3] = 50;
    phase_mask[4] = 16'h0000;                  phase_len[4] = 30;
    phase_mask[5] = 16'($urandom_range(0, 65535)); phase_len[5] = 70;
    phase_mask[6] = 16'hFFFF;                  phase_len[6] = 60;
    for (int p = 0; p < 7; p++) begin
      write_channel_mask(phase_mask[p]);
      burst_phase = (p == 5);
      queue_random_events(phase_len[p]);
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lva_pkg.sv
hdl/lva_voice_ram.sv
hdl/lru_voice_allocator.sv
hdl/lva_checker.sv
verif/tb.sv
